FILE: hw/rtl/amsr_pkg.sv
// Shared types and constants for the alpha mask span rectangle block.
`default_nettype none
package amsr_pkg;

    localparam int CFG_W     = 14;              // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 14;              // positions and effective tile dimensions
    localparam int STEP_W    = 3;
    localparam int ALPHA_W   = 8;
    localparam int OUT_W     = 14;
    localparam int PROD_W    = POS_W + CFG_W;   // position times logical dimension
    localparam int NUM_W     = PROD_W + 1;      // product plus rounding bias
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int JQ_DEPTH  = 2;

    localparam logic [CFG_W-1:0]   RST_DIM  = CFG_W'(1);
    localparam logic [STEP_W-1:0]  RST_STEP = STEP_W'(2);
    localparam logic [ALPHA_W-1:0] RST_THR  = ALPHA_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_W    = 3'd0,
        REG_TILE_H    = 3'd1,
        REG_LOGICAL_W = 3'd2,
        REG_LOGICAL_H = 3'd3,
        REG_STEP      = 3'd4,
        REG_ALPHA_THR = 3'd5
    } t_reg_idx;

    // tile dimensions and step already clamped to usable values
    typedef struct packed {
        logic [POS_W-1:0]   tw;
        logic [POS_W-1:0]   th;
        logic [CFG_W-1:0]   lw;
        logic [CFG_W-1:0]   lh;
        logic [STEP_W-1:0]  step;
        logic [ALPHA_W-1:0] thr;
    } t_cfg;

    // one rectangle in physical units, waiting for scaling
    typedef struct packed {
        logic [POS_W-1:0] x_lo;
        logic [POS_W-1:0] x_hi;
        logic [POS_W-1:0] y_lo;
        logic [POS_W-1:0] y_hi;
    } t_job;

    typedef enum logic [1:0] {
        OP_X_LO = 2'd0,
        OP_X_HI = 2'd1,
        OP_Y_LO = 2'd2,
        OP_Y_HI = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_LOAD = 3'd2,
        BK_DIV  = 3'd3,
        BK_DONE = 3'd4
    } t_bstate;

endpackage
`default_nettype wire

FILE: hw/rtl/alpha_mask_span_rectangles.sv
// Top level: configuration registers, front end, job queue and scaling back end.
//
//  channel   | signals                                  | word
//  ----------+------------------------------------------+----------------------------
//  samples   | push, full, i_alpha                      | one alpha byte
//  rects     | empty, pop, o_rect_x/y/w/h               | one rectangle, logical units
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data          | one register write
//
//  The front end takes a sample every cycle while the two-entry job queue has room.
//  Each rectangle costs four scalings in the back end, each one multiply, one
//  load and a bit-serial divide, plus take and hand-over; the next job is taken only after hand-over.
//  A rectangle waits in the output register until popped; the queue absorbs the rest.
//  Reset is synchronous and needs no clearing pass; the registers return to defaults.
`default_nettype none
module alpha_mask_span_rectangles #(
    parameter int MAX_DIM = 8192
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [amsr_pkg::ALPHA_W-1:0]    i_alpha,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [amsr_pkg::OUT_W-1:0]           o_rect_x,
    output logic [amsr_pkg::OUT_W-1:0]           o_rect_y,
    output logic [amsr_pkg::OUT_W-1:0]           o_rect_w,
    output logic [amsr_pkg::OUT_W-1:0]           o_rect_h,
    input  wire logic                            i_cfg_we,
    input  wire logic [amsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [amsr_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CW = amsr_pkg::CFG_W;
    localparam int PW = amsr_pkg::POS_W;

    logic [CW-1:0]                   r_tile_w, r_tile_h, r_log_w, r_log_h;
    logic [amsr_pkg::STEP_W-1:0]     r_step;
    logic [amsr_pkg::ALPHA_W-1:0]    r_thr;

    amsr_pkg::t_cfg  cfg;
    amsr_pkg::t_job  fe_job, q_job;
    logic            accept, fe_job_valid, q_valid, q_full, job_take, pop_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= amsr_pkg::RST_DIM;
            r_tile_h <= amsr_pkg::RST_DIM;
            r_log_w  <= amsr_pkg::RST_DIM;
            r_log_h  <= amsr_pkg::RST_DIM;
            r_step   <= amsr_pkg::RST_STEP;
            r_thr    <= amsr_pkg::RST_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                amsr_pkg::REG_TILE_W:    r_tile_w <= i_cfg_data;
                amsr_pkg::REG_TILE_H:    r_tile_h <= i_cfg_data;
                amsr_pkg::REG_LOGICAL_W: r_log_w  <= i_cfg_data;
                amsr_pkg::REG_LOGICAL_H: r_log_h  <= i_cfg_data;
                amsr_pkg::REG_STEP:      r_step   <= i_cfg_data[amsr_pkg::STEP_W-1:0];
                amsr_pkg::REG_ALPHA_THR: r_thr    <= i_cfg_data[amsr_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversized tiles clamp to MAX_DIM
    always_comb begin
        if (r_tile_w == '0) begin
            cfg.tw = PW'(1);
        end else if (32'(r_tile_w) > 32'(MAX_DIM)) begin
            cfg.tw = PW'(MAX_DIM);
        end else begin
            cfg.tw = PW'(r_tile_w);
        end
        if (r_tile_h == '0) begin
            cfg.th = PW'(1);
        end else if (32'(r_tile_h) > 32'(MAX_DIM)) begin
            cfg.th = PW'(MAX_DIM);
        end else begin
            cfg.th = PW'(r_tile_h);
        end
        cfg.lw   = r_log_w;
        cfg.lh   = r_log_h;
        cfg.step = (r_step == '0) ? amsr_pkg::STEP_W'(1) : r_step;
        cfg.thr  = r_thr;
    end

    assign full   = q_full;
    assign accept = push && !q_full;
    assign pop_ok = pop && !empty;

    amsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_alpha     (i_alpha),
        .o_job_valid (fe_job_valid),
        .o_job       (fe_job)
    );

    amsr_jobq u_jobq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (fe_job_valid),
        .i_wr_data (fe_job),
        .i_rd_en   (job_take),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_rd_data (q_job)
    );

    amsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_take  (job_take),
        .i_pop       (pop_ok),
        .o_empty     (empty),
        .o_rect_x    (o_rect_x),
        .o_rect_y    (o_rect_y),
        .o_rect_w    (o_rect_w),
        .o_rect_h    (o_rect_h)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/amsr_front.sv
// Front end: sample counters, opacity test and run tracking.
`default_nettype none
module amsr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire amsr_pkg::t_cfg                i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [amsr_pkg::ALPHA_W-1:0]  i_alpha,
    output logic                               o_job_valid,
    output amsr_pkg::t_job                     o_job
);

    localparam int PW = amsr_pkg::POS_W;

    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_row, n_row;
    logic          r_run_open, n_run_open;
    logic [PW-1:0] r_run_start, n_run_start;

    logic          opaque, last, emit_end, emit_last, open_now, row_wrap;
    logic [PW:0]   col_sum, row_sum;
    logic [PW-1:0] bottom;

    always_comb begin
        opaque    = i_alpha > i_cfg.thr;
        col_sum   = {1'b0, r_col} + (PW+1)'(i_cfg.step);
        row_sum   = {1'b0, r_row} + (PW+1)'(i_cfg.step);
        last      = col_sum >= {1'b0, i_cfg.tw};
        row_wrap  = row_sum >= {1'b0, i_cfg.th};
        bottom    = row_wrap ? i_cfg.th : row_sum[PW-1:0];
        open_now  = r_run_open || opaque;
        emit_end  = !opaque && r_run_open;
        emit_last = last && open_now && !emit_end;

        n_run_start = (opaque && !r_run_open) ? r_col : r_run_start;
        n_run_open  = open_now && !emit_end && !last;
        if (last) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_sum[PW-1:0];
        end else begin
            n_col = col_sum[PW-1:0];
            n_row = r_row;
        end

        o_job_valid = i_accept && (emit_end || emit_last);
        o_job.x_lo  = n_run_start;
        o_job.x_hi  = emit_end ? r_col : i_cfg.tw;
        o_job.y_lo  = r_row;
        o_job.y_hi  = bottom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
        end else if (i_accept) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/amsr_jobq.sv
// Short queue of rectangle jobs between front and back end.
`default_nettype none
module amsr_jobq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire amsr_pkg::t_job  i_wr_data,
    input  wire logic            i_rd_en,
    output logic                 o_full,
    output logic                 o_valid,
    output amsr_pkg::t_job       o_rd_data
);

    localparam int DEPTH = amsr_pkg::JQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    amsr_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_wr, do_rd;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_valid   = r_count != '0;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/amsr_back.sv
// Back end: scales a job to logical units with one multiplier and one bit-serial divider.
`default_nettype none
module amsr_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire amsr_pkg::t_cfg               i_cfg,
    input  wire logic                         i_job_valid,
    input  wire amsr_pkg::t_job               i_job,
    output logic                              o_job_take,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [amsr_pkg::OUT_W-1:0]        o_rect_x,
    output logic [amsr_pkg::OUT_W-1:0]        o_rect_y,
    output logic [amsr_pkg::OUT_W-1:0]        o_rect_w,
    output logic [amsr_pkg::OUT_W-1:0]        o_rect_h
);

    localparam int PW  = amsr_pkg::POS_W;
    localparam int NW  = amsr_pkg::NUM_W;
    localparam int CW  = amsr_pkg::CNT_W;
    localparam int OW  = amsr_pkg::OUT_W;

    amsr_pkg::t_bstate              r_state, n_state;
    amsr_pkg::t_op                  r_op;
    amsr_pkg::t_job                 r_job;
    logic [CW-1:0]                  r_cnt;
    logic [amsr_pkg::PROD_W-1:0]    r_prod;
    logic [NW-1:0]                  r_num;
    logic [PW-1:0]                  r_rem;
    logic [NW-1:0]                  r_q [4];
    logic                           r_out_valid;
    logic [OW-1:0]                  r_rect_x, r_rect_y, r_rect_w, r_rect_h;

    logic [PW-1:0]                  opnd, divisor, bias;
    logic [amsr_pkg::CFG_W-1:0]     lmul;
    logic [PW:0]                    rem_sh, rem_nx;
    logic                           ge, div_last, out_free, fin;
    logic [NW-1:0]                  num_nx, w_full, h_full;

    always_comb begin
        unique case (r_op)
            amsr_pkg::OP_X_LO: opnd = r_job.x_lo;
            amsr_pkg::OP_X_HI: opnd = r_job.x_hi;
            amsr_pkg::OP_Y_LO: opnd = r_job.y_lo;
            amsr_pkg::OP_Y_HI: opnd = r_job.y_hi;
            default:           opnd = r_job.x_lo;
        endcase
        if (r_op == amsr_pkg::OP_X_LO || r_op == amsr_pkg::OP_X_HI) begin
            lmul    = i_cfg.lw;
            divisor = i_cfg.tw;
        end else begin
            lmul    = i_cfg.lh;
            divisor = i_cfg.th;
        end
        // right and bottom edges round up
        bias = (r_op == amsr_pkg::OP_X_HI || r_op == amsr_pkg::OP_Y_HI) ?
               divisor - 1'b1 : '0;

        rem_sh   = {r_rem, r_num[NW-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_nx   = ge ? rem_sh - {1'b0, divisor} : rem_sh;
        num_nx   = {r_num[NW-2:0], ge};
        div_last = r_cnt == CW'(NW - 1);

        w_full = (r_q[amsr_pkg::OP_X_HI] > r_q[amsr_pkg::OP_X_LO]) ?
                 r_q[amsr_pkg::OP_X_HI] - r_q[amsr_pkg::OP_X_LO] : '0;
        h_full = (r_q[amsr_pkg::OP_Y_HI] > r_q[amsr_pkg::OP_Y_LO]) ?
                 r_q[amsr_pkg::OP_Y_HI] - r_q[amsr_pkg::OP_Y_LO] : '0;
        out_free = !r_out_valid || i_pop;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amsr_pkg::BK_IDLE: if (i_job_valid) n_state = amsr_pkg::BK_MUL;
            amsr_pkg::BK_MUL:  n_state = amsr_pkg::BK_LOAD;
            amsr_pkg::BK_LOAD: n_state = amsr_pkg::BK_DIV;
            amsr_pkg::BK_DIV: begin
                if (div_last) begin
                    n_state = (r_op == amsr_pkg::OP_Y_HI) ? amsr_pkg::BK_DONE
                                                          : amsr_pkg::BK_MUL;
                end
            end
            amsr_pkg::BK_DONE: if (out_free) n_state = amsr_pkg::BK_IDLE;
            default:           n_state = amsr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_take = (r_state == amsr_pkg::BK_IDLE) && i_job_valid;
        fin        = (r_state == amsr_pkg::BK_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amsr_pkg::BK_IDLE;
            r_op        <= amsr_pkg::OP_X_LO;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_job_take) begin
                r_op <= amsr_pkg::OP_X_LO;
            end else if (r_state == amsr_pkg::BK_DIV && div_last) begin
                r_op <= amsr_pkg::t_op'(r_op + 2'd1);
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
        if (r_state == amsr_pkg::BK_MUL) begin
            r_prod <= amsr_pkg::PROD_W'(opnd) * amsr_pkg::PROD_W'(lmul);
        end
        if (r_state == amsr_pkg::BK_LOAD) begin
            r_num <= NW'(r_prod) + NW'(bias);
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (r_state == amsr_pkg::BK_DIV) begin
            r_num <= num_nx;
            r_rem <= rem_nx[PW-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (div_last) begin
                r_q[r_op] <= num_nx;
            end
        end
        if (fin) begin
            r_rect_x <= r_q[amsr_pkg::OP_X_LO][OW-1:0];
            r_rect_y <= r_q[amsr_pkg::OP_Y_LO][OW-1:0];
            r_rect_w <= w_full[OW-1:0];
            r_rect_h <= h_full[OW-1:0];
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_rect_x = r_rect_x;
    assign o_rect_y = r_rect_y;
    assign o_rect_w = r_rect_w;
    assign o_rect_h = r_rect_h;

endmodule
`default_nettype wire

FILE: sim/alpha_mask_span_rectangles_tb.sv
// Testbench for alpha_mask_span_rectangles: directed plan, then random tiles against a predictor.
module alpha_mask_span_rectangles_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W     = amsr_pkg::CFG_W;
    localparam int CFG_IDX_W = amsr_pkg::CFG_IDX_W;
    localparam int POS_W     = amsr_pkg::POS_W;
    localparam int STEP_W    = amsr_pkg::STEP_W;
    localparam int ALPHA_W   = amsr_pkg::ALPHA_W;
    localparam int OUT_W     = amsr_pkg::OUT_W;

    localparam int LIMIT      = 1_000_000;
    localparam int SETTLE     = 300;    // a little over two rectangles through the scaler
    localparam int RAND_ITEMS = 800;
    localparam int CALM_ITEMS = 100;
    localparam int MAX_TILE   = 8192;
    localparam int PLAN_MAX   = 64;
    localparam int DUE_DEPTH  = 64;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] w;
        logic [OUT_W-1:0] h;
    } t_rect;

    typedef enum logic [1:0] {
        ROW_CFG,    // register write
        ROW_PRED,   // sample, checked against the predictor
        ROW_RECT,   // sample, typed rectangle
        ROW_NONE    // sample, no rectangle
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_rect                rect;
    } t_plan_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 push       = 1'b0;
    logic [ALPHA_W-1:0]   i_alpha    = '0;
    logic                 pop        = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 full;
    logic                 empty;
    logic [OUT_W-1:0]     o_rect_x, o_rect_y, o_rect_w, o_rect_h;

    // predictor copy of the registers and the span tracker
    logic [CFG_W-1:0]   reg_tw   = amsr_pkg::RST_DIM;
    logic [CFG_W-1:0]   reg_th   = amsr_pkg::RST_DIM;
    logic [CFG_W-1:0]   reg_lw   = amsr_pkg::RST_DIM;
    logic [CFG_W-1:0]   reg_lh   = amsr_pkg::RST_DIM;
    logic [STEP_W-1:0]  reg_step = amsr_pkg::RST_STEP;
    logic [ALPHA_W-1:0] reg_thr  = amsr_pkg::RST_THR;
    logic [POS_W-1:0]   col_pos    = '0;
    logic [POS_W-1:0]   row_pos    = '0;
    logic [POS_W-1:0]   span_start = '0;
    bit                 span_open  = 1'b0;

    // expected rectangles, oldest at due_head
    t_rect     due_mem [DUE_DEPTH];
    int        due_head = 0;
    int        due_tail = 0;
    t_plan_row plan [PLAN_MAX];
    int        plan_len   = 0;
    int        miss_count = 0;
    int        cycles     = 0;
    bit        calm       = 1'b0;
    int        sink_rate  = 0;
    int        stall_left = 0;
    int        sink_ticks = 0;

    alpha_mask_span_rectangles i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_alpha    (i_alpha),
        .empty      (empty),
        .pop        (pop),
        .o_rect_x   (o_rect_x),
        .o_rect_y   (o_rect_y),
        .o_rect_w   (o_rect_w),
        .o_rect_h   (o_rect_h),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_miss(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        miss_count++;
    endtask

    function automatic void due_add(input t_rect r);
        due_mem[due_tail % DUE_DEPTH] = r;
        due_tail++;
    endfunction

    function automatic void plan_add(input t_plan_row p);
        plan[plan_len] = p;
        plan_len++;
    endfunction

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_TILE)
            return MAX_TILE;
        return 32'(v);
    endfunction

    // One sample through the span tracker; returns 1 when it closes a rectangle.
    function automatic bit trace_span(input logic [ALPHA_W-1:0] a, output t_rect r);
        int unsigned     tw, th, s, right, bottom;
        longint unsigned x0, x1, y0, y1;
        bit              opaque, last, hit;
        tw     = clamp_dim(reg_tw);
        th     = clamp_dim(reg_th);
        s      = (reg_step == 0) ? 1 : 32'(reg_step);
        opaque = a > reg_thr;
        last   = 32'(col_pos) + s >= tw;
        hit    = 1'b0;
        right  = 0;
        r      = '0;
        if (opaque && !span_open) begin
            span_start = col_pos;
            span_open  = 1'b1;
        end
        if (!opaque && span_open) begin
            hit       = 1'b1;
            right     = 32'(col_pos);
            span_open = 1'b0;
        end else if (last && span_open) begin
            hit       = 1'b1;
            right     = tw;
            span_open = 1'b0;
        end
        if (hit) begin
            // left/top floor, right/bottom ceiling, bottom clipped to the tile
            x0     = 64'(span_start) * 64'(reg_lw) / 64'(tw);
            x1     = (64'(right) * 64'(reg_lw) + 64'(tw) - 1) / 64'(tw);
            bottom = (32'(row_pos) + s < th) ? 32'(row_pos) + s : th;
            y0     = 64'(row_pos) * 64'(reg_lh) / 64'(th);
            y1     = (64'(bottom) * 64'(reg_lh) + 64'(th) - 1) / 64'(th);
            r.x    = x0[OUT_W-1:0];
            r.y    = y0[OUT_W-1:0];
            r.w    = (x1 > x0) ? OUT_W'(x1 - x0) : '0;
            r.h    = (y1 > y0) ? OUT_W'(y1 - y0) : '0;
        end
        if (last) begin
            col_pos   = '0;
            span_open = 1'b0;
            row_pos   = (32'(row_pos) + s >= th) ? '0 : POS_W'(32'(row_pos) + s);
        end else begin
            col_pos = POS_W'(32'(col_pos) + s);
        end
        return hit;
    endfunction

    // caller lowers the write enable after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            amsr_pkg::REG_TILE_W:    reg_tw   = d;
            amsr_pkg::REG_TILE_H:    reg_th   = d;
            amsr_pkg::REG_LOGICAL_W: reg_lw   = d;
            amsr_pkg::REG_LOGICAL_H: reg_lh   = d;
            amsr_pkg::REG_STEP:      reg_step = d[STEP_W-1:0];
            amsr_pkg::REG_ALPHA_THR: reg_thr  = d[ALPHA_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic feed_alpha(input logic [ALPHA_W-1:0] a, output bit hit, output t_rect r);
        push    <= 1'b1;
        i_alpha <= a;
        do
            @(posedge i_clk);
        while (full !== 1'b0);
        hit = trace_span(a, r);
    endtask

    task automatic maybe_pause(input int rate);
        if (!calm && $urandom_range(0, 99) < rate) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // wait until every rectangle is out, then let the scaler run dry
    task automatic settle_idle();
        push <= 1'b0;
        while (due_tail != due_head)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'(MAX_TILE);
            2:       return '1;
            3:       return CFG_W'($urandom_range(MAX_TILE + 1, 16383));
            4:       return CFG_W'($urandom_range(21, MAX_TILE - 1));
            default: return CFG_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_scale(input logic [CFG_W-1:0] base);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom);
            3:       return CFG_W'(base * 2);
            4:       return CFG_W'($urandom_range(1, 40));
            default: return base;
        endcase
    endfunction

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] d);
        t_plan_row p;
        p      = '0;
        p.kind = ROW_CFG;
        p.idx  = idx;
        p.data = d;
        return p;
    endfunction

    function automatic t_plan_row alpha_row(input t_row_kind k, input logic [ALPHA_W-1:0] a,
                                            input int x = 0, input int y = 0,
                                            input int w = 0, input int h = 0);
        t_plan_row p;
        p      = '0;
        p.kind = k;
        p.data = CFG_W'(a);
        p.rect = '{x: OUT_W'(x), y: OUT_W'(y), w: OUT_W'(w), h: OUT_W'(h)};
        return p;
    endfunction

    // result side: check each popped word, stall in random bursts
    always @(posedge i_clk) begin
        t_rect want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (due_tail == due_head) begin
                    report_miss("unexpected rectangle, x", int'(o_rect_x), 0);
                end else begin
                    want = due_mem[due_head % DUE_DEPTH];
                    due_head++;
                    if (o_rect_x !== want.x)
                        report_miss("rect_x", int'(o_rect_x), int'(want.x));
                    if (o_rect_y !== want.y)
                        report_miss("rect_y", int'(o_rect_y), int'(want.y));
                    if (o_rect_w !== want.w)
                        report_miss("rect_w", int'(o_rect_w), int'(want.w));
                    if (o_rect_h !== want.h)
                        report_miss("rect_h", int'(o_rect_h), int'(want.h));
                end
            end
            sink_ticks++;
            if (sink_ticks % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0:       sink_rate = 0;
                    1:       sink_rate = 5;
                    default: sink_rate = 25;
                endcase
            end
            if (stall_left != 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < sink_rate) begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        bit    hit;
        bit    dense;
        t_rect guess;
        int    sent, burst, src_rate, thr, a;

        dense = 1'b0;
        sent  = 0;

        // reset values: 1x1 tile, step 2, so every sample ends its row
        plan_add(alpha_row(ROW_RECT, 8'd255, 0, 0, 1, 1));
        plan_add(alpha_row(ROW_RECT, 8'd9, 0, 0, 1, 1));
        plan_add(alpha_row(ROW_NONE, 8'd8));
        plan_add(alpha_row(ROW_NONE, 8'd0));
        // 6x5 tile at unit scale, threshold zero
        plan_add(cfg_row(amsr_pkg::REG_TILE_W, 14'd6));
        plan_add(cfg_row(amsr_pkg::REG_TILE_H, 14'd5));
        plan_add(cfg_row(amsr_pkg::REG_LOGICAL_W, 14'd6));
        plan_add(cfg_row(amsr_pkg::REG_LOGICAL_H, 14'd5));
        plan_add(cfg_row(amsr_pkg::REG_STEP, 14'd2));
        plan_add(cfg_row(amsr_pkg::REG_ALPHA_THR, 14'd0));
        plan_add(alpha_row(ROW_NONE, 8'd1));
        plan_add(alpha_row(ROW_RECT, 8'd0, 0, 0, 2, 2));
        plan_add(alpha_row(ROW_RECT, 8'd1, 4, 0, 2, 2));     // opens and closes at row end
        plan_add(alpha_row(ROW_NONE, 8'd255));
        plan_add(alpha_row(ROW_NONE, 8'd255));
        plan_add(alpha_row(ROW_RECT, 8'd255, 0, 2, 6, 2));
        plan_add(alpha_row(ROW_NONE, 8'd0));
        plan_add(alpha_row(ROW_NONE, 8'd1));
        plan_add(alpha_row(ROW_RECT, 8'd0, 2, 4, 2, 1));     // bottom clipped
        plan_add(cfg_row(amsr_pkg::REG_ALPHA_THR, 14'd255));
        plan_add(alpha_row(ROW_PRED, 8'd255));
        plan_add(alpha_row(ROW_PRED, 8'd255));
        // shrink the tile under the column counter, zero logical width
        plan_add(cfg_row(amsr_pkg::REG_TILE_W, 14'd3));
        plan_add(cfg_row(amsr_pkg::REG_LOGICAL_W, 14'd0));
        plan_add(cfg_row(amsr_pkg::REG_ALPHA_THR, 14'd0));
        plan_add(alpha_row(ROW_PRED, 8'd200));
        // zero step and height, oversize width, largest logical size
        plan_add(cfg_row(amsr_pkg::REG_STEP, 14'd0));
        plan_add(cfg_row(amsr_pkg::REG_TILE_W, 14'h3FFF));
        plan_add(cfg_row(amsr_pkg::REG_TILE_H, 14'd0));
        plan_add(cfg_row(amsr_pkg::REG_LOGICAL_W, 14'h3FFF));
        plan_add(cfg_row(amsr_pkg::REG_LOGICAL_H, 14'h3FFF));
        plan_add(alpha_row(ROW_PRED, 8'd255));
        plan_add(alpha_row(ROW_PRED, 8'd0));
        plan_add(alpha_row(ROW_PRED, 8'd128));
        // stride of seven, zero width, upper data bits set, spare indexes
        plan_add(cfg_row(amsr_pkg::REG_STEP, 14'h3FFF));
        plan_add(cfg_row(amsr_pkg::REG_TILE_W, 14'd0));
        plan_add(cfg_row(REG_SPARE_A, 14'h3FFF));
        plan_add(cfg_row(REG_SPARE_B, 14'h1555));
        plan_add(cfg_row(amsr_pkg::REG_ALPHA_THR, 14'h3F80));
        plan_add(alpha_row(ROW_PRED, 8'd129));
        plan_add(alpha_row(ROW_PRED, 8'd128));
        plan_add(alpha_row(ROW_PRED, 8'd127));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < plan_len; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                if (k == 0 || plan[k-1].kind != ROW_CFG)
                    settle_idle();
                write_reg(plan[k].idx, plan[k].data);
                if (k + 1 == plan_len || plan[k+1].kind != ROW_CFG)
                    i_cfg_we <= 1'b0;
            end else begin
                feed_alpha(plan[k].data[ALPHA_W-1:0], hit, guess);
                if (plan[k].kind == ROW_RECT)
                    due_add(plan[k].rect);
                else if (plan[k].kind == ROW_PRED && hit)
                    due_add(guess);
                maybe_pause(20);
            end
        end

        while (sent < RAND_ITEMS) begin
            settle_idle();
            write_reg(amsr_pkg::REG_TILE_W, pick_dim());
            write_reg(amsr_pkg::REG_TILE_H, pick_dim());
            write_reg(amsr_pkg::REG_LOGICAL_W, pick_scale(reg_tw));
            write_reg(amsr_pkg::REG_LOGICAL_H, pick_scale(reg_th));
            if ($urandom_range(0, 3) == 0)
                write_reg(amsr_pkg::REG_STEP, {11'($urandom), 3'($urandom_range(0, 7))});
            else
                write_reg(amsr_pkg::REG_STEP, CFG_W'($urandom_range(1, 4)));
            case ($urandom_range(0, 5))
                0:       write_reg(amsr_pkg::REG_ALPHA_THR, 14'd0);
                1:       write_reg(amsr_pkg::REG_ALPHA_THR, 14'd255);
                default: write_reg(amsr_pkg::REG_ALPHA_THR, CFG_W'($urandom));
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
            i_cfg_we <= 1'b0;

            case ($urandom_range(0, 2))
                0:       src_rate = 0;
                1:       src_rate = 10;
                default: src_rate = 40;
            endcase
            burst = $urandom_range(40, 120);
            for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
                calm = (sent >= RAND_ITEMS - CALM_ITEMS);
                thr  = int'(reg_thr);
                // mostly runs of opaque and clear samples, some at the threshold itself
                case ($urandom_range(0, 9))
                    0: a = $urandom_range(0, 255);
                    1: a = thr;
                    2: a = (thr + 1) % 256;
                    default: begin
                        if ($urandom_range(0, 3) == 0)
                            dense = !dense;
                        if (dense && thr < 255)
                            a = $urandom_range(thr + 1, 255);
                        else
                            a = $urandom_range(0, thr);
                    end
                endcase
                feed_alpha(ALPHA_W'(a), hit, guess);
                if (hit)
                    due_add(guess);
                sent++;
                maybe_pause(src_rate);
            end
        end

        settle_idle();
        if (miss_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/amsr_pkg.sv
hw/rtl/amsr_front.sv
hw/rtl/amsr_jobq.sv
hw/rtl/amsr_back.sv
hw/rtl/alpha_mask_span_rectangles.sv
sim/alpha_mask_span_rectangles_tb.sv
